### src/ofs_pkg.sv
// ----------------------------------------------------------------------------
// ofs_pkg
// Shared types, constants and pattern tables of the optical frame serialiser.
// ----------------------------------------------------------------------------
package ofs_pkg;

    localparam int PAYLOAD_DEPTH = 256;
    localparam int ADDR_W        = $clog2(PAYLOAD_DEPTH);
    localparam int BITS_PER_BYTE = 8;
    localparam int PREAMBLE_LEN  = 16;
    localparam int VIS_LEN       = 4;
    localparam int LEN_W         = 9;
    localparam int BITS_W        = 5;

    localparam logic [7:0] STOP_BYTE = 8'hFF;
    localparam logic [7:0] MSB_MASK  = 8'h80;

    // Phase register, one-hot.
    typedef enum logic [4:0] {
        PH_VIS  = 5'b00001,
        PH_PRE  = 5'b00010,
        PH_PAY  = 5'b00100,
        PH_STOP = 5'b01000,
        PH_OFF  = 5'b10000
    } t_phase;

    // Input word kinds.
    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_LOAD  = 2'd1,
        MODE_START = 2'd2
    } t_mode;

    // Phase code shown with every line bit.
    localparam logic [1:0] FP_VIS  = 2'd0;
    localparam logic [1:0] FP_PRE  = 2'd1;
    localparam logic [1:0] FP_PAY  = 2'd2;
    localparam logic [1:0] FP_STOP = 2'd3;

    // Configuration register indexes (APB address bit 2).
    localparam logic REG_RLL = 1'b0;
    localparam logic REG_VIS = 1'b1;

    typedef struct packed {
        logic rll_enable;
        logic visibility_enable;
    } t_cfg;

    function automatic logic [7:0] preamble_byte(input logic [3:0] idx);
        logic [7:0] v;
        case (idx)
            4'd12:   v = 8'h9A;
            4'd13:   v = 8'hD7;
            4'd14:   v = 8'h65;
            4'd15:   v = 8'h28;
            default: v = 8'h55;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] vis_byte(input logic [1:0] idx);
        logic [7:0] v;
        case (idx)
            2'd0:    v = 8'hE2;
            2'd1:    v = 8'hD4;
            2'd2:    v = 8'hB1;
            default: v = 8'h39;
        endcase
        return v;
    endfunction

endpackage

### src/ofs_if.sv
// ----------------------------------------------------------------------------
// ofs_in_if / ofs_out_if
// Valid/ready channels carrying input words and line-bit words.
// ----------------------------------------------------------------------------
interface ofs_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [7:0] buffer_address;
    logic [7:0] payload_byte;
    logic [8:0] frame_length;

    modport source (output valid, mode, buffer_address, payload_byte, frame_length,
                    input ready);
    modport sink   (input valid, mode, buffer_address, payload_byte, frame_length,
                    output ready);
endinterface

interface ofs_out_if;
    logic       valid;
    logic       ready;
    logic       line_bit;
    logic [1:0] frame_phase;
    logic       byte_start;

    modport source (output valid, line_bit, frame_phase, byte_start, input ready);
    modport sink   (input valid, line_bit, frame_phase, byte_start, output ready);
endinterface

### src/optical_frame_serializer_top.sv
// ----------------------------------------------------------------------------
// optical_frame_serializer_top
// Bit-serial optical transmitter: preamble, payload (optionally Manchester
// coded), then a repeating visibility pattern or a single stop byte.
// ----------------------------------------------------------------------------
// Usage
//   i_in carries input words: a tick asks for one line bit, a load writes a
//   payload byte into the 256-entry buffer, a start begins a frame of
//   frame_length bytes (zero is ignored, more than 256 is clamped).
//   o_out carries one word per tick while the transmitter is active: the
//   line level, the frame phase and a first-bit-of-byte flag. Ticks while
//   off, loads and starts give no word.
//   The APB port sets the RLL enable (0x0) and visibility enable (0x4).
//   Throughput is one input word per cycle while o_out is not stalled; a
//   line-bit word appears, from the output register, in the cycle after
//   its tick. The payload buffer is read in the cycle before each fetch,
//   so no fetch waits; a load to the entry being read bypasses the memory.
//   While o_out is stalled with a word held, i_in is not ready; a word
//   taken in the same cycle it leaves is replaced at once.
//   Reset leaves the transmitter off with both enables set; the buffer
//   contents are undefined until loaded.
// ----------------------------------------------------------------------------
module optical_frame_serializer_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ofs_in_if.sink        i_in,
    ofs_out_if.source     o_out,
    input  logic          i_psel,
    input  logic          i_penable,
    input  logic          i_pwrite,
    input  logic [2:0]    i_paddr,
    input  logic [31:0]   i_pwdata,
    output logic [31:0]   o_prdata,
    output logic          o_pready
);
    import ofs_pkg::*;

    t_cfg w_cfg;

    ofs_apb_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready),
        .o_cfg     (w_cfg)
    );

    // Transmitter state.
    t_phase             r_phase,     n_phase;
    logic [7:0]         r_shift,     n_shift;
    logic [BITS_W-1:0]  r_bits_left, n_bits_left;
    logic [ADDR_W-1:0]  r_src,       n_src;
    logic [LEN_W-1:0]   r_bytes,     n_bytes;
    logic [LEN_W-1:0]   r_send_len,  n_send_len;
    logic               r_first,     n_first;

    // Output register.
    logic               r_out_valid, n_out_valid;
    logic               r_line,      n_line;
    logic [1:0]         r_fphase,    n_fphase;
    logic               r_bstart,    n_bstart;

    // Payload buffer with registered read and write forwarding.
    logic [7:0]         r_payload_mem [PAYLOAD_DEPTH];
    logic [7:0]         r_mem_q;
    logic               r_fwd_hit;
    logic [7:0]         r_fwd_data;
    logic [7:0]         w_mem_byte;
    logic [ADDR_W-1:0]  w_rd_addr;
    logic               w_wr_en;

    logic               w_in_ready;
    logic               w_acc;
    logic               w_tick;
    logic               w_load;
    logic               w_start;
    logic [BITS_W-1:0]  w_bits_dec;

    // Byte fetch results, worked out from the present state.
    t_phase             f_phase;
    logic [ADDR_W-1:0]  f_src_base;
    logic [LEN_W-1:0]   f_bytes_base;
    logic               f_off;
    logic [7:0]         f_byte;

    assign w_in_ready = !r_out_valid || o_out.ready;
    assign i_in.ready = w_in_ready;
    assign w_acc      = i_in.valid && w_in_ready;
    assign w_tick     = w_acc && (i_in.mode == MODE_TICK);
    assign w_load     = w_acc && (i_in.mode == MODE_LOAD);
    assign w_start    = w_acc && (i_in.mode == MODE_START) && (i_in.frame_length != '0);
    assign w_wr_en    = w_load;
    assign w_bits_dec = r_bits_left - BITS_W'(1);
    assign w_mem_byte = r_fwd_hit ? r_fwd_data : r_mem_q;

    assign o_out.valid       = r_out_valid;
    assign o_out.line_bit    = r_line;
    assign o_out.frame_phase = r_fphase;
    assign o_out.byte_start  = r_bstart;

    // Read the entry the next payload fetch will use: the first entry when
    // the current phase is used up, otherwise the running index.
    assign w_rd_addr = (n_bytes == '0) ? '0 : n_src;

    always_comb begin
        f_phase      = r_phase;
        f_src_base   = r_src;
        f_bytes_base = r_bytes;
        f_off        = 1'b0;
        if (r_bytes == '0) begin
            f_src_base = '0;
            case (r_phase)
                PH_VIS: begin
                    f_phase      = PH_VIS;
                    f_bytes_base = LEN_W'(VIS_LEN);
                end
                PH_PRE: begin
                    f_phase      = PH_PAY;
                    f_bytes_base = r_send_len;
                end
                PH_PAY: begin
                    if (w_cfg.visibility_enable) begin
                        f_phase      = PH_VIS;
                        f_bytes_base = LEN_W'(VIS_LEN);
                    end else begin
                        f_phase      = PH_STOP;
                        f_bytes_base = LEN_W'(1);
                    end
                end
                default: begin
                    f_off      = 1'b1;
                    f_src_base = r_src;
                end
            endcase
        end
        case (f_phase)
            PH_VIS:  f_byte = (f_src_base < ADDR_W'(VIS_LEN)) ?
                              vis_byte(f_src_base[1:0]) : 8'h00;
            PH_PRE:  f_byte = (f_src_base < ADDR_W'(PREAMBLE_LEN)) ?
                              preamble_byte(f_src_base[3:0]) : 8'h00;
            PH_PAY:  f_byte = w_mem_byte;
            default: f_byte = STOP_BYTE;
        endcase
    end

    always_comb begin
        n_phase     = r_phase;
        n_shift     = r_shift;
        n_bits_left = r_bits_left;
        n_src       = r_src;
        n_bytes     = r_bytes;
        n_send_len  = r_send_len;
        n_first     = r_first;
        n_out_valid = r_out_valid && !o_out.ready;
        n_line      = r_line;
        n_fphase    = r_fphase;
        n_bstart    = r_bstart;

        if (w_start) begin
            n_send_len  = (i_in.frame_length > LEN_W'(PAYLOAD_DEPTH)) ?
                          LEN_W'(PAYLOAD_DEPTH) : i_in.frame_length;
            n_phase     = PH_PRE;
            n_shift     = preamble_byte(4'd0);
            n_src       = ADDR_W'(1);
            n_bytes     = LEN_W'(PREAMBLE_LEN - 1);
            n_bits_left = BITS_W'(BITS_PER_BYTE);
            n_first     = 1'b1;
        end else if (w_tick && (r_phase != PH_OFF)) begin
            n_out_valid = 1'b1;
            n_line      = r_shift[7];
            n_bstart    = r_first;
            n_first     = 1'b0;
            case (r_phase)
                PH_VIS:  n_fphase = FP_VIS;
                PH_PRE:  n_fphase = FP_PRE;
                PH_PAY:  n_fphase = FP_PAY;
                PH_STOP: n_fphase = FP_STOP;
                default: n_fphase = FP_VIS;
            endcase
            if (w_bits_dec != '0) begin
                n_bits_left = w_bits_dec;
                // The odd half of a Manchester pair is the complement.
                if (w_cfg.rll_enable && (r_phase == PH_PAY) && w_bits_dec[0]) begin
                    n_shift = r_shift ^ MSB_MASK;
                end else begin
                    n_shift = {r_shift[6:0], 1'b0};
                end
            end else if (f_off) begin
                n_phase     = PH_OFF;
                n_bits_left = '0;
            end else begin
                n_phase     = f_phase;
                n_shift     = f_byte;
                n_src       = f_src_base + ADDR_W'(1);
                n_bytes     = f_bytes_base - LEN_W'(1);
                n_bits_left = ((f_phase == PH_PAY) && w_cfg.rll_enable) ?
                              BITS_W'(2 * BITS_PER_BYTE) : BITS_W'(BITS_PER_BYTE);
                n_first     = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_OFF;
            r_shift     <= '0;
            r_bits_left <= '0;
            r_src       <= '0;
            r_bytes     <= '0;
            r_send_len  <= '0;
            r_first     <= 1'b0;
            r_out_valid <= 1'b0;
            r_fwd_hit   <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_shift     <= n_shift;
            r_bits_left <= n_bits_left;
            r_src       <= n_src;
            r_bytes     <= n_bytes;
            r_send_len  <= n_send_len;
            r_first     <= n_first;
            r_out_valid <= n_out_valid;
            r_fwd_hit   <= w_wr_en && (i_in.buffer_address == w_rd_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        r_line     <= n_line;
        r_fphase   <= n_fphase;
        r_bstart   <= n_bstart;
        r_fwd_data <= i_in.payload_byte;
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_payload_mem[i_in.buffer_address] <= i_in.payload_byte;
        end
        r_mem_q <= r_payload_mem[w_rd_addr];
    end

`ifndef SYNTH
    a_zero_start_ignored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (i_in.mode == MODE_START) && (i_in.frame_length == '0) &&
         !(i_in.valid && i_in.mode == MODE_TICK))
        |=> $stable(r_phase))
        else $error("zero-length start changed the phase");

    a_start_enters_preamble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |=> (r_phase == PH_PRE) && r_first && (r_bits_left == BITS_W'(BITS_PER_BYTE)))
        else $error("start did not begin the preamble");

    a_active_has_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_OFF) |-> (r_bits_left != '0))
        else $error("active phase with no bits left");

    a_load_no_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && !r_out_valid) |=> !r_out_valid)
        else $error("load produced a line-bit word");

    a_bytes_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bytes <= LEN_W'(PAYLOAD_DEPTH))
        else $error("byte count beyond the buffer depth");
`endif

endmodule

### src/ofs_apb_regs.sv
// ----------------------------------------------------------------------------
// ofs_apb_regs
// APB register file holding the RLL and visibility enables.
// ----------------------------------------------------------------------------
module ofs_apb_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_psel,
    input  logic          i_penable,
    input  logic          i_pwrite,
    input  logic [2:0]    i_paddr,
    input  logic [31:0]   i_pwdata,
    output logic [31:0]   o_prdata,
    output logic          o_pready,
    output ofs_pkg::t_cfg o_cfg
);
    import ofs_pkg::*;

    t_cfg r_cfg;
    logic w_wr;

    assign w_wr     = i_psel && i_penable && i_pwrite;
    assign o_pready = 1'b1;
    assign o_cfg    = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rll_enable        <= 1'b1;
            r_cfg.visibility_enable <= 1'b1;
        end else if (w_wr) begin
            case (i_paddr[2])
                REG_RLL: r_cfg.rll_enable        <= i_pwdata[0];
                REG_VIS: r_cfg.visibility_enable <= i_pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (i_paddr[2])
            REG_RLL: o_prdata = {31'd0, r_cfg.rll_enable};
            REG_VIS: o_prdata = {31'd0, r_cfg.visibility_enable};
            default: o_prdata = 32'd0;
        endcase
    end

endmodule

### test/optical_frame_serializer_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// optical_frame_serializer_top_test
// Self-checking bench for the optical frame serialiser. A queue of command
// words (ticks, buffer loads, frame starts and noise) feeds a valid/ready
// driver; every accepted word is run through a line-bit predictor kept in
// this file, and a monitor compares each line-bit word with the oldest
// prediction. Both channels stall at random. The enables are changed over
// APB between phases, only while no word is outstanding.
// ----------------------------------------------------------------------------
module optical_frame_serializer_top_test;
    import ofs_pkg::*;

    localparam logic [1:0] MODE_UNUSED   = 2'd3;
    localparam logic [7:0] PREAMBLE_FILL = 8'h55;
    localparam int         SYNC_START    = 12;
    localparam logic [7:0] PREAMBLE_SYNC [0:3] = '{8'h9A, 8'hD7, 8'h65, 8'h28};
    localparam logic [7:0] VIS_PATTERN   [0:3] = '{8'hE2, 8'hD4, 8'hB1, 8'h39};
    localparam int         IDLE_LIMIT    = 2000;
    localparam int         DRAIN_CYCLES  = 6;
    localparam int         QUEUE_HIGH    = 64;
    localparam int         PHASE_WORDS   = 40;
    localparam int         FILL_DEPTH    = 32;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] addr;
        logic [7:0] data;
        logic [8:0] len;
    } t_tx_cmd;

    typedef struct packed {
        logic       line_bit;
        logic [1:0] frame_phase;
        logic       byte_start;
    } t_line_word;

    logic        i_clk     = 1'b0;
    logic        i_rst_n   = 1'b0;
    logic        drv_valid = 1'b0;
    t_tx_cmd     drv_cmd   = '0;
    logic        out_ready = 1'b0;
    logic        apb_sel    = 1'b0;
    logic        apb_enable = 1'b0;
    logic        apb_write  = 1'b0;
    logic [2:0]  apb_addr   = '0;
    logic [31:0] apb_wdata  = '0;
    logic [31:0] o_prdata;
    logic        o_pready;

    ofs_in_if  cmd_if ();
    ofs_out_if line_if ();

    assign cmd_if.valid          = drv_valid;
    assign cmd_if.mode           = drv_cmd.mode;
    assign cmd_if.buffer_address = drv_cmd.addr;
    assign cmd_if.payload_byte   = drv_cmd.data;
    assign cmd_if.frame_length   = drv_cmd.len;
    assign line_if.ready         = out_ready;

    optical_frame_serializer_top dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (cmd_if),
        .o_out     (line_if),
        .i_psel    (apb_sel),
        .i_penable (apb_enable),
        .i_pwrite  (apb_write),
        .i_paddr   (apb_addr),
        .i_pwdata  (apb_wdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready)
    );

    always #6 i_clk = ~i_clk;

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Line-bit predictor
    // ------------------------------------------------------------------
    logic       rll_on = 1'b1;
    logic       vis_on = 1'b1;
    t_phase     tx_phase = PH_OFF;
    logic [7:0] tx_shift = '0;
    logic [4:0] tx_bits_left = '0;
    int         tx_src = 0;
    int         tx_bytes_left = 0;
    int         tx_send_len = 0;
    logic       tx_first = 1'b0;
    logic [7:0] tx_buffer [0:PAYLOAD_DEPTH-1];

    t_tx_cmd    cmd_queue [$];
    t_line_word line_expect [$];
    int         effective_words = 0;
    int         mismatches = 0;

    function automatic void begin_phase(input t_phase p, input int count);
        tx_phase      = p;
        tx_src        = 0;
        tx_bytes_left = count;
    endfunction

    // Fetch the next byte of the frame, moving on when a phase is used up.
    function automatic void load_next_byte();
        logic [7:0] v;
        if (tx_bytes_left == 0) begin
            case (tx_phase)
                PH_VIS: begin_phase(PH_VIS, VIS_LEN);
                PH_PRE: begin_phase(PH_PAY, tx_send_len);
                PH_PAY: begin
                    if (vis_on) begin_phase(PH_VIS, VIS_LEN);
                    else begin_phase(PH_STOP, 1);
                end
                default: begin
                    tx_phase     = PH_OFF;
                    tx_bits_left = '0;
                    tx_first     = 1'b0;
                    return;
                end
            endcase
        end
        case (tx_phase)
            PH_VIS:  v = VIS_PATTERN[tx_src];
            PH_PRE:  v = (tx_src < SYNC_START) ? PREAMBLE_FILL
                                               : PREAMBLE_SYNC[tx_src - SYNC_START];
            PH_PAY:  v = tx_buffer[tx_src];
            default: v = STOP_BYTE;
        endcase
        tx_src++;
        tx_bytes_left--;
        tx_shift     = v;
        tx_bits_left = (tx_phase == PH_PAY && rll_on) ? 5'(2 * BITS_PER_BYTE)
                                                       : 5'(BITS_PER_BYTE);
        tx_first     = 1'b1;
    endfunction

    function automatic void serialise_cmd(input t_tx_cmd c);
        t_line_word w;
        int         n;
        case (c.mode)
            MODE_LOAD: tx_buffer[c.addr] = c.data;
            MODE_START: begin
                if (c.len != 0) begin
                    n = (c.len > PAYLOAD_DEPTH) ? PAYLOAD_DEPTH : int'(c.len);
                    tx_send_len = n;
                    begin_phase(PH_PRE, PREAMBLE_LEN);
                    load_next_byte();
                end
            end
            MODE_TICK: begin
                if (tx_phase != PH_OFF) begin
                    w.line_bit   = tx_shift[7];
                    w.byte_start = tx_first;
                    case (tx_phase)
                        PH_VIS:  w.frame_phase = FP_VIS;
                        PH_PRE:  w.frame_phase = FP_PRE;
                        PH_PAY:  w.frame_phase = FP_PAY;
                        default: w.frame_phase = FP_STOP;
                    endcase
                    line_expect.push_back(w);
                    tx_first     = 1'b0;
                    tx_bits_left = tx_bits_left - 5'd1;
                    if (tx_bits_left != 0) begin
                        // Odd counts in a coded payload byte send the complement.
                        if (rll_on && tx_phase == PH_PAY && tx_bits_left[0])
                            tx_shift[7] = ~tx_shift[7];
                        else
                            tx_shift = tx_shift << 1;
                    end else begin
                        load_next_byte();
                    end
                end
            end
            default: ;
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 1;
        if (r < 85) return $urandom_range(2, 4);
        if (r < 97) return $urandom_range(5, 12);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------
    // Command driver
    // ------------------------------------------------------------------
    int   drv_gap_left = 0;
    int   drv_calm_left = 0;
    logic drv_calm = 1'b0;

    always @(posedge i_clk) begin
        logic take_next;
        if (!i_rst_n) begin
            drv_valid <= 1'b0;
        end else begin
            take_next = !drv_valid;
            if (drv_calm_left == 0) begin
                drv_calm      = ($urandom_range(0, 3) == 0);
                drv_calm_left = $urandom_range(50, 400);
            end else begin
                drv_calm_left--;
            end
            if (drv_valid && cmd_if.ready) begin
                if (drv_cmd.mode == MODE_LOAD
                        || (drv_cmd.mode == MODE_START && drv_cmd.len != 0)
                        || (drv_cmd.mode == MODE_TICK && tx_phase != PH_OFF))
                    effective_words++;
                serialise_cmd(drv_cmd);
                take_next    = 1'b1;
                drv_gap_left = (drv_calm || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
            end
            if (take_next) begin
                if (drv_gap_left != 0) begin
                    drv_gap_left--;
                    drv_valid <= 1'b0;
                end else if (cmd_queue.size() != 0) begin
                    drv_cmd   <= cmd_queue.pop_front();
                    drv_valid <= 1'b1;
                end else begin
                    drv_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Line-bit monitor
    // ------------------------------------------------------------------
    int   mon_stall_left = 0;
    int   mon_calm_left = 0;
    logic mon_calm = 1'b0;

    always @(posedge i_clk) begin
        t_line_word got;
        t_line_word want;
        if (i_rst_n && line_if.valid && out_ready) begin
            got.line_bit    = line_if.line_bit;
            got.frame_phase = line_if.frame_phase;
            got.byte_start  = line_if.byte_start;
            if (line_expect.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected line word: bit %0b phase %0d first %0b",
                             got.line_bit, got.frame_phase, got.byte_start);
            end else begin
                want = line_expect.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"line word: expected bit %0b phase %0d first %0b, ",
                                  "got bit %0b phase %0d first %0b"},
                                 want.line_bit, want.frame_phase, want.byte_start,
                                 got.line_bit, got.frame_phase, got.byte_start);
                end
            end
        end
        if (mon_calm_left == 0) begin
            mon_calm      = ($urandom_range(0, 3) == 0);
            mon_calm_left = $urandom_range(50, 400);
        end else begin
            mon_calm_left--;
        end
        if (mon_stall_left != 0) begin
            mon_stall_left--;
            out_ready <= 1'b0;
        end else if (!mon_calm && $urandom_range(0, 99) < 20) begin
            mon_stall_left = pick_gap() - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: ends the run when nothing moves for too long.
    // ------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if ((drv_valid && cmd_if.ready) || (line_if.valid && out_ready) || apb_sel)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles == IDLE_LIMIT) begin
            $display("optical_frame_serializer_top: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic push_cmd(input logic [1:0] mode, input logic [7:0] addr,
                            input logic [7:0] data, input logic [8:0] len);
        t_tx_cmd c;
        c.mode = mode;
        c.addr = addr;
        c.data = data;
        c.len  = len;
        while (cmd_queue.size() >= QUEUE_HIGH) @(posedge i_clk);
        cmd_queue.push_back(c);
    endtask

    // Ticks carry random content in the fields that the block ignores.
    // Noise words are loads anywhere (only once the low entries are filled),
    // unused-mode words and zero-length starts.
    task automatic push_ticks(input int count, input logic noisy);
        int r;
        for (int i = 0; i < count; i++) begin
            if (noisy && $urandom_range(0, 99) < 6) begin
                r = $urandom_range(0, 2);
                if (r == 0)
                    push_cmd(MODE_LOAD, 8'($urandom()), 8'($urandom()), 9'($urandom()));
                else if (r == 1)
                    push_cmd(MODE_UNUSED, 8'($urandom()), 8'($urandom()), 9'($urandom()));
                else
                    push_cmd(MODE_START, 8'($urandom()), 8'($urandom()), 9'd0);
            end
            push_cmd(MODE_TICK, 8'($urandom()), 8'($urandom()), 9'($urandom()));
        end
    endtask

    function automatic int frame_ticks(input int len);
        int n;
        n = (len > PAYLOAD_DEPTH) ? PAYLOAD_DEPTH : len;
        return PREAMBLE_LEN * BITS_PER_BYTE + n * BITS_PER_BYTE * (rll_on ? 2 : 1);
    endfunction

    task automatic wait_drained();
        do @(negedge i_clk);
        while (cmd_queue.size() != 0 || drv_valid || line_expect.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic value);
        @(posedge i_clk);
        apb_sel    <= 1'b1;
        apb_enable <= 1'b0;
        apb_write  <= 1'b1;
        apb_addr   <= {idx, 2'b00};
        apb_wdata  <= {31'($urandom()), value};
        @(posedge i_clk);
        apb_enable <= 1'b1;
        do @(posedge i_clk); while (!o_pready);
        apb_sel    <= 1'b0;
        apb_enable <= 1'b0;
        apb_write  <= 1'b0;
        if (idx == REG_RLL) rll_on = value;
        else vis_on = value;
    endtask

    task automatic set_enables(input logic rll, input logic vis);
        wait_drained();
        write_reg(REG_RLL, rll);
        write_reg(REG_VIS, vis);
    endtask

    task automatic send_random_frame();
        int len;
        int n;
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)      len = $urandom_range(1, 4);
        else if (r < 90) len = $urandom_range(5, 16);
        else             len = $urandom_range(200, 511);
        repeat ($urandom_range(0, 3))
            push_cmd(MODE_LOAD, 8'($urandom_range(0, (len > 256 ? 256 : len) - 1)),
                     8'($urandom()), 9'($urandom()));
        push_cmd(MODE_START, 8'($urandom()), 8'($urandom()), 9'(len));
        if (len > 16)
            n = $urandom_range(1, 300);
        else if ($urandom_range(0, 99) < 35)
            n = $urandom_range(1, frame_ticks(len));
        else
            n = frame_ticks(len) + (vis_on ? $urandom_range(0, 40)
                                           : BITS_PER_BYTE + $urandom_range(0, 10));
        push_ticks(n, 1'b1);
    endtask

    task automatic run_traffic(input int quota);
        int goal;
        goal = effective_words + quota;
        while (effective_words < goal) send_random_frame();
    endtask

    // Leaves the block part way into a payload byte, so that the next
    // register write lands in the middle of it.
    task automatic stop_in_payload();
        push_cmd(MODE_START, 8'($urandom()), 8'($urandom()), 9'd3);
        push_ticks(PREAMBLE_LEN * BITS_PER_BYTE + 5, 1'b0);
    endtask

    // Runs a short frame to its end: visibility when enabled, else off.
    task automatic run_past_end();
        push_cmd(MODE_START, 8'($urandom()), 8'($urandom()), 9'd1);
        push_ticks(frame_ticks(1) + 20, 1'b0);
    endtask

    initial begin
        wait (i_rst_n);
        @(posedge i_clk);

        // Directed part; only entries 0 to 3 and 255 are written until the fill.
        push_cmd(MODE_TICK, 8'hFF, 8'hFF, 9'h1FF);
        push_cmd(MODE_UNUSED, 8'h00, 8'h00, 9'd5);
        push_cmd(MODE_START, 8'h00, 8'h00, 9'd0);
        push_cmd(MODE_LOAD, 8'd0, 8'h00, 9'd0);
        push_cmd(MODE_LOAD, 8'd1, 8'hFF, 9'd0);
        push_cmd(MODE_LOAD, 8'd2, 8'hA5, 9'd0);
        push_cmd(MODE_LOAD, 8'd3, 8'h5A, 9'd0);
        push_cmd(MODE_LOAD, 8'd255, 8'hC3, 9'd0);
        push_cmd(MODE_START, 8'h00, 8'h00, 9'd2);
        push_ticks(PREAMBLE_LEN * BITS_PER_BYTE + 4, 1'b0);
        // Byte 1 has not been fetched yet, so its new value goes out.
        push_cmd(MODE_LOAD, 8'd1, 8'h81, 9'd0);
        push_cmd(MODE_START, 8'h00, 8'h00, 9'd0);
        push_ticks(40, 1'b0);
        push_cmd(MODE_START, 8'h00, 8'h00, 9'd4);
        push_ticks(10, 1'b0);
        push_cmd(MODE_START, 8'h00, 8'h00, 9'd3);
        push_ticks(frame_ticks(3) + 40, 1'b0);

        // Fill the low entries; no frame below ticks far enough to read past them.
        for (int a = 0; a < FILL_DEPTH; a++)
            push_cmd(MODE_LOAD, 8'(a), 8'($urandom()), 9'($urandom()));

        stop_in_payload();
        set_enables(1'b0, 1'b1);
        run_traffic(PHASE_WORDS);
        run_past_end();
        // Visibility is running, so clearing its enable must not stop it.
        set_enables(1'b0, 1'b0);
        push_ticks(20, 1'b0);
        // A length beyond the buffer, followed into its first payload bytes.
        push_cmd(MODE_START, 8'($urandom()), 8'($urandom()), 9'($urandom_range(257, 511)));
        push_ticks(PREAMBLE_LEN * BITS_PER_BYTE + 3 * BITS_PER_BYTE, 1'b1);
        run_traffic(PHASE_WORDS);
        stop_in_payload();
        set_enables(1'b1, 1'b0);
        run_traffic(PHASE_WORDS);
        run_past_end();
        set_enables(1'b1, 1'b1);
        run_traffic(PHASE_WORDS);

        wait_drained();
        if (mismatches == 0 && line_expect.size() == 0) begin
            $display("optical_frame_serializer_top: match");
        end else begin
            $display("optical_frame_serializer_top: mismatch");
        end
        $finish;
    end

endmodule
